// ----- design/srmm_pkg.sv -----
// Shared types and constants for the sorted row membership mask block.
`default_nettype none

package srmm_pkg;

  // Fixed field widths of a beat
  localparam int unsigned ROW_BITS = 20;
  localparam int unsigned POS_BITS = 12;

  // Default buffer depth in entries
  localparam int unsigned LIST_DEPTH_DEFAULT = 4096;

  // Operation carried by an input beat
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef struct packed {
    func_e               func;
    logic [ROW_BITS-1:0] row_index;
    logic                first_of_list;
  } in_item_t;

  typedef struct packed {
    logic                in_descendant;
    logic [POS_BITS-1:0] parent_position;
    logic                overflowed;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/srmm_row_buf.sv -----
// Descendant row buffer: one write port, one read port, registered read data.
`default_nettype none

module srmm_row_buf #(
  parameter int unsigned DEPTH = srmm_pkg::LIST_DEPTH_DEFAULT,
  localparam int unsigned AddrBits = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AddrBits-1:0]           waddr_i,
  input  wire logic [srmm_pkg::ROW_BITS-1:0] wdata_i,
  input  wire logic                          re_i,
  input  wire logic [AddrBits-1:0]           raddr_i,
  output      logic [srmm_pkg::ROW_BITS-1:0] rdata_o
);

  logic [srmm_pkg::ROW_BITS-1:0] mem_q [DEPTH];
  logic [srmm_pkg::ROW_BITS-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/sorted_row_membership_mask_core.sv -----
// Top level: load descendant rows into a buffer, answer parent row membership queries.
//
//   channel | dir | payload               | handshake
//   --------+-----+-----------------------+---------------------------
//   in      | in  | srmm_pkg::in_item_t   | in_valid_i / in_ready_o
//   out     | out | srmm_pkg::out_item_t  | out_valid_o / out_ready_i
//
// A load beat writes the buffer in its accept cycle; a load into a full buffer sets the overflow flag.
// A query with the scan pointer at the list end misses without a read; else the scan reads
// entries, one read a cycle, and stops on the first entry not below the query row or steps off the end.
// A query waits in the done state while the output register stays stalled.
// Reset clears count, pointers and flags at once; the buffer needs no clear pass.
// Input is held off during a scan; a result held in the output register does not block it.
`default_nettype none

module sorted_row_membership_mask_core #(
  parameter int unsigned LIST_DEPTH = srmm_pkg::LIST_DEPTH_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire srmm_pkg::in_item_t  in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      srmm_pkg::out_item_t out_item_o
);

  localparam int unsigned AddrBits = $clog2(LIST_DEPTH);
  localparam int unsigned CntBits  = $clog2(LIST_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [CntBits-1:0]              count_q, count_d;
  logic [CntBits-1:0]              scan_q, scan_d;
  logic [CntBits-1:0]              scan_next;
  logic [srmm_pkg::POS_BITS-1:0]   qpos_q, qpos_d;
  logic                            ovf_q, ovf_d;
  logic [srmm_pkg::ROW_BITS-1:0]   qrow_q, qrow_d;
  logic [srmm_pkg::POS_BITS-1:0]   res_pos_q, res_pos_d;
  logic                            res_hit_q, res_hit_d;
  logic                            out_valid_q, out_valid_d;
  srmm_pkg::out_item_t             out_item_q, out_item_d;

  logic                            in_acc;
  logic                            slot_free;
  logic                            out_load;
  logic                            hit_cur;
  logic [srmm_pkg::POS_BITS-1:0]   pos_cur;

  logic                            mem_we, mem_re;
  logic [AddrBits-1:0]             mem_waddr, mem_raddr;
  logic [srmm_pkg::ROW_BITS-1:0]   mem_rdata;

  srmm_row_buf #(
    .DEPTH (LIST_DEPTH)
  ) u_row_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_item_i.row_index),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;
  assign scan_next  = scan_q + CntBits'(1);

  // Sequencer: loads write straight away, queries step through the buffer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    scan_d    = scan_q;
    qpos_d    = qpos_q;
    ovf_d     = ovf_q;
    qrow_d    = qrow_q;
    res_pos_d = res_pos_q;
    res_hit_d = res_hit_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[AddrBits-1:0];
    mem_re    = 1'b0;
    mem_raddr = scan_q[AddrBits-1:0];
    out_load  = 1'b0;
    hit_cur   = 1'b0;
    pos_cur   = res_pos_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.func == srmm_pkg::FUNC_LOAD) begin
            if (in_item_i.first_of_list) begin
              // new list: first row goes to entry zero
              mem_we    = 1'b1;
              mem_waddr = '0;
              count_d   = CntBits'(1);
              scan_d    = '0;
              qpos_d    = '0;
              ovf_d     = 1'b0;
            end else if (count_q < CntBits'(LIST_DEPTH)) begin
              mem_we  = 1'b1;
              count_d = count_q + CntBits'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            qrow_d    = in_item_i.row_index;
            res_pos_d = qpos_q;
            qpos_d    = qpos_q + srmm_pkg::POS_BITS'(1);
            if (scan_q < count_q) begin
              mem_re  = 1'b1;
              state_d = ST_CMP;
            end else begin
              // scan already at the end: miss without a read
              res_hit_d = 1'b0;
              pos_cur   = qpos_q;
              if (slot_free) begin
                out_load = 1'b1;
              end else begin
                state_d = ST_DONE;
              end
            end
          end
        end
      end

      ST_CMP: begin
        if (mem_rdata < qrow_q) begin
          scan_d = scan_next;
          if (scan_next < count_q) begin
            mem_re    = 1'b1;
            mem_raddr = scan_next[AddrBits-1:0];
          end else begin
            res_hit_d = 1'b0;
            hit_cur   = 1'b0;
            if (slot_free) begin
              out_load = 1'b1;
              state_d  = ST_IDLE;
            end else begin
              state_d = ST_DONE;
            end
          end
        end else begin
          res_hit_d = (mem_rdata == qrow_q);
          hit_cur   = (mem_rdata == qrow_q);
          if (slot_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        hit_cur = res_hit_q;
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_load) begin
      out_valid_d                = 1'b1;
      out_item_d.in_descendant   = hit_cur;
      out_item_d.parent_position = pos_cur;
      out_item_d.overflowed      = ovf_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      qpos_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      qpos_q      <= qpos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    qrow_q     <= qrow_d;
    res_pos_q  <= res_pos_d;
    res_hit_q  <= res_hit_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- design/srmm_checker.sv -----
// Port-level checks for the sorted row membership mask block, bound to the top level.
`default_nettype none

module srmm_port_props (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire srmm_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire srmm_pkg::out_item_t out_item_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed");

  // a load never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.func == srmm_pkg::FUNC_LOAD) && !out_valid_o
    |=> !out_valid_o)
    else $error("result appeared after a load");

  // after a query the block is either scanning or has a result up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.func == srmm_pkg::FUNC_QUERY)
    |=> !in_ready_o || out_valid_o)
    else $error("query accepted but neither scanning nor answered");

  // no result while reset is held
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind sorted_row_membership_mask_core srmm_port_props u_srmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ----- bench/srmm_checker.sv -----
// Scoreboard for the sorted row membership mask block: tracks beats, predicts and compares.
`timescale 1ns / 1ps

module srmm_checker
  import srmm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_item_t  in_item_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_item_t out_item_i,
  output int             fail_count_o,
  output int             waiting_o
);

  // Predicted block state
  logic [ROW_BITS-1:0] held_rows [LIST_DEPTH];
  int unsigned         held_count;
  int unsigned         scan_idx;
  logic [POS_BITS-1:0] next_pos;
  logic                rows_lost;

  // Membership answers still owed by the block, oldest first
  out_item_t           answers_q [$];

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      held_count   = 0;
      scan_idx     = 0;
      next_pos     = '0;
      rows_lost    = 1'b0;
      fail_count_o = 0;
      answers_q.delete();
    end else begin
      // Input beat: update the list or predict the answer
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.func == FUNC_LOAD) begin
          if (in_item_i.first_of_list) begin
            held_count = 0;
            scan_idx   = 0;
            next_pos   = '0;
            rows_lost  = 1'b0;
          end
          if (held_count < LIST_DEPTH) begin
            held_rows[held_count] = in_item_i.row_index;
            held_count++;
          end else begin
            rows_lost = 1'b1;
          end
        end else begin
          // pointer only moves forward, past smaller held rows
          while (scan_idx < held_count && held_rows[scan_idx] < in_item_i.row_index)
            scan_idx++;
          want.in_descendant   = (scan_idx < held_count) &&
                                 (held_rows[scan_idx] == in_item_i.row_index);
          want.parent_position = next_pos;
          want.overflowed      = rows_lost;
          answers_q.push_back(want);
          next_pos = next_pos + 1'b1;
        end
      end

      // Output beat: compare with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got = out_item_i;
        if (answers_q.size() == 0) begin
          $display("%0t: result beat with none expected, got %b/%0d/%b", $time,
                   got.in_descendant, got.parent_position, got.overflowed);
          fail_count_o++;
        end else begin
          want = answers_q.pop_front();
          if (got.in_descendant !== want.in_descendant) begin
            $display("%0t: in_descendant expected %b, got %b", $time,
                     want.in_descendant, got.in_descendant);
            fail_count_o++;
          end
          if (got.parent_position !== want.parent_position) begin
            $display("%0t: parent_position expected %0d, got %0d", $time,
                     want.parent_position, got.parent_position);
            fail_count_o++;
          end
          if (got.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %b, got %b", $time,
                     want.overflowed, got.overflowed);
            fail_count_o++;
          end
        end
      end
    end
    waiting_o = answers_q.size();
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top: drives load and query beats into the membership mask block, gives the verdict.
`timescale 1ns / 1ps

module tb;
  import srmm_pkg::*;

  localparam int unsigned         DEPTH       = LIST_DEPTH_DEFAULT;
  localparam int unsigned         LONG_ROWS   = 100;
  localparam logic [ROW_BITS-1:0] ROW_MAX     = '1;
  localparam int unsigned         CYCLE_LIMIT = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  int          fail_count;
  int          waiting;
  logic        steady = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent   = 0;

  sorted_row_membership_mask_core #(
    .LIST_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  srmm_checker #(
    .LIST_DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .waiting_o   (waiting)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sorted_row_membership_mask_core test failed");
      $finish;
    end
  end

  // Result side: stalls at random unless in a steady stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready <= steady || ($urandom_range(99) >= 11);
    end
  end

  // One input beat, with random idle cycles ahead of it
  task automatic send_beat(input in_item_t beat);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_item  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic load_row(input logic [ROW_BITS-1:0] row, input logic first);
    send_beat(in_item_t'{func: FUNC_LOAD, row_index: row, first_of_list: first});
  endtask

  task automatic query_row(input logic [ROW_BITS-1:0] row, input logic first);
    send_beat(in_item_t'{func: FUNC_QUERY, row_index: row, first_of_list: first});
  endtask

  // Hold the input off until every answer is back
  task automatic wait_answers();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
  endtask

  // Mostly well-formed lists (ascending loads, then ascending queries), some noise
  task automatic random_lists(input int unsigned target);
    logic [ROW_BITS-1:0] rows [64];
    logic [ROW_BITS-1:0] cur;
    logic [ROW_BITS-1:0] q;
    int unsigned         first_sent;
    int unsigned         n;
    int unsigned         m;
    int unsigned         j;
    int unsigned         k;
    first_sent = sent;
    while (sent - first_sent < target) begin
      if ($urandom_range(9) == 0) begin
        // noise: any operation, any row, any mark, in any order
        repeat ($urandom_range(1, 6))
          send_beat(in_item_t'{func: func_e'($urandom_range(0, 1)),
                               row_index: ROW_BITS'($urandom()),
                               first_of_list: 1'($urandom_range(0, 1))});
      end else begin
        n   = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 10);
        cur = ROW_BITS'($urandom());
        for (k = 0; k < n; k++) begin
          rows[k] = cur;
          cur     = cur + ROW_BITS'($urandom_range(0, (ROW_MAX - cur) >> 3));
        end
        // now and then the list is appended to the previous one
        for (k = 0; k < n; k++)
          load_row(rows[k], (k == 0) && ($urandom_range(7) != 0));
        m = $urandom_range(0, 12);
        q = ROW_BITS'($urandom_range(0, rows[0]));
        j = 0;
        for (k = 0; k < m; k++) begin
          while (j < n && rows[j] < q) j++;
          if (j < n && $urandom_range(1) == 1) q = rows[j];
          else q = q + ROW_BITS'($urandom_range(0, (ROW_MAX - q) >> 2));
          query_row(q, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // One long list, walked by a long run of ascending queries
  task automatic long_list();
    int unsigned k;
    for (k = 0; k < LONG_ROWS; k++)
      load_row(ROW_BITS'(k * 255 + $urandom_range(0, 254)), k == 0);
    for (k = 0; k < LONG_ROWS; k++)
      query_row(ROW_BITS'(k * 255 + $urandom_range(0, 254)), 1'b0);
    // a fresh list restarts the positions
    load_row(20'h3C3C3, 1'b1);
    query_row(20'h3C3C3, 1'b0);
  endtask

  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // query on an empty list, then a query carrying the new-list mark
    query_row('0, 1'b0);
    query_row(ROW_MAX, 1'b1);
    // new list with the row extremes
    load_row('0, 1'b1);
    load_row(20'd5, 1'b0);
    load_row(ROW_MAX, 1'b0);
    query_row('0, 1'b0);
    query_row(20'd3, 1'b0);
    query_row(20'd5, 1'b0);
    query_row(ROW_MAX, 1'b0);
    query_row(ROW_MAX, 1'b0);
    // append after queries, out of order: pointer is kept, so a miss
    load_row(20'h7FFFF, 1'b0);
    query_row(20'h7FFFF, 1'b0);
    // query below the previous one: pointer never moves back
    query_row(20'd2, 1'b0);
    // alternating bit patterns
    load_row(20'hAAAAA, 1'b1);
    query_row(20'h55555, 1'b0);
    query_row(20'hAAAAA, 1'b0);
    // scan runs off the end
    load_row(20'h12345, 1'b1);
    query_row(ROW_MAX, 1'b0);
    query_row(20'h12345, 1'b0);
    wait_answers();

    random_lists(180);
    steady = 1'b1;
    random_lists(90);
    steady = 1'b0;
    wait_answers();
    long_list();
    random_lists(180);

    // drain and let the block settle
    wait_answers();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sorted_row_membership_mask_core test passed");
    end else begin
      $display("sorted_row_membership_mask_core test failed");
    end
    $finish;
  end

endmodule
